/* sv/ple_pkg.sv */
// Shared types and constants of the positional list engine.
// No dependencies; the interfaces, controller, datapath, top and testbench import this package.
package ple_pkg;

   localparam int unsigned CAPACITY_DEFAULT = 16;
   localparam int unsigned POS_W            = 8;
   localparam int unsigned VALUE_W          = 32;
   localparam int unsigned LEN_W            = 5;

   // Request kinds.
   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_DELETE = 1'b1;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;       // capture a request
      logic shift_rd;   // read the neighbor of the current index
      logic shift_wr;   // write read data at the current index and step it
      logic taken_rd;   // read the element at the request position
      logic taken_cap;  // keep the element that a delete takes out
      logic value_wr;   // write the new value at the request position
      logic commit;     // update the count and the result register
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_delete;
      logic fail;
      logic more;
   } stat_type;

endpackage

/* sv/ple_if.sv */
// Request and response channel interfaces of the positional list engine.
// Depends on ple_pkg for the payload widths and the status type.
interface ple_req_if;
   import ple_pkg::*;

   logic                      valid;
   logic                      ready;
   logic                      req_type;
   logic [POS_W-1:0]          position;
   logic signed [VALUE_W-1:0] value;

   modport source (output valid, req_type, position, value, input ready);
   modport sink (input valid, req_type, position, value, output ready);
endinterface

interface ple_rsp_if;
   import ple_pkg::*;

   logic                      valid;
   logic                      ready;
   status_type                status;
   logic signed [VALUE_W-1:0] removed_value;
   logic [LEN_W-1:0]          length;

   modport source (output valid, status, removed_value, length, input ready);
   modport sink (input valid, status, removed_value, length, output ready);
endinterface

/* sv/ple_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ple_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 16
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

/* sv/ple_ctrl.sv */
// Controller of the positional list engine: sequences the element shifts.
// Depends on ple_pkg for the command and status structs.
module ple_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  ple_pkg::stat_type stat,
   output ple_pkg::cmd_type  cmd
);
   import ple_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_INS_LOOP,
      S_INS_WR,
      S_DEL_CAP,
      S_DEL_LOOP,
      S_DEL_WR,
      S_RESP
   } state_type;

   state_type state_ff, state_in;
   logic      req_ready_ff, req_ready_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      req_ready_in = req_ready_ff;
      rsp_valid_in = rsp_valid_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready_ff) begin
               cmd.load     = 1'b1;
               req_ready_in = 1'b0;
               state_in     = S_CHECK;
            end
         end
         S_CHECK: begin
            if (stat.fail) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_RESP;
            end else if (stat.is_delete) begin
               cmd.taken_rd = 1'b1;
               state_in     = S_DEL_CAP;
            end else begin
               state_in = S_INS_LOOP;
            end
         end
         S_INS_LOOP: begin
            if (stat.more) begin
               cmd.shift_rd = 1'b1;
               state_in     = S_INS_WR;
            end else begin
               cmd.value_wr = 1'b1;
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_RESP;
            end
         end
         S_INS_WR: begin
            cmd.shift_wr = 1'b1;
            state_in     = S_INS_LOOP;
         end
         S_DEL_CAP: begin
            cmd.taken_cap = 1'b1;
            state_in      = S_DEL_LOOP;
         end
         S_DEL_LOOP: begin
            if (stat.more) begin
               cmd.shift_rd = 1'b1;
               state_in     = S_DEL_WR;
            end else begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_RESP;
            end
         end
         S_DEL_WR: begin
            cmd.shift_wr = 1'b1;
            state_in     = S_DEL_LOOP;
         end
         S_RESP: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               req_ready_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         req_ready_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         req_ready_ff <= req_ready_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = req_ready_ff;
   assign rsp_valid = rsp_valid_ff;

   // A new request is never taken while a result is pending.
   a_ready_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_ready_ff && rsp_valid_ff))
      else $error("request ready while a response is pending");

   // Every accepted request reaches the check state next.
   a_load_check: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == S_CHECK)
      else $error("accepted request did not enter the check state");

   // A finished response transfer reopens the request side.
   a_resp_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ready) |=> req_ready_ff && !rsp_valid_ff)
      else $error("response transfer did not reopen the request side");
endmodule

/* sv/ple_dpath.sv */
// Datapath of the positional list engine: element RAM, count, shift index, result.
// Depends on ple_pkg and ple_ram.
module ple_dpath #(
   parameter int unsigned CAPACITY = ple_pkg::CAPACITY_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_type,
   input  logic [ple_pkg::POS_W-1:0]          req_position,
   input  logic signed [ple_pkg::VALUE_W-1:0] req_value,
   input  ple_pkg::cmd_type                   cmd,
   output ple_pkg::stat_type                  stat,
   output ple_pkg::status_type                rsp_status,
   output logic signed [ple_pkg::VALUE_W-1:0] rsp_removed_value,
   output logic [ple_pkg::LEN_W-1:0]          rsp_length
);
   import ple_pkg::*;

   localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int unsigned CW = $clog2(CAPACITY + 1);
   localparam int unsigned PW = POS_W + 1;

   logic                      kind_ff, kind_in;
   logic [POS_W-1:0]          pos_ff, pos_in;
   logic signed [VALUE_W-1:0] val_ff, val_in;
   logic [AW-1:0]             idx_ff, idx_in;
   logic [CW-1:0]             count_ff, count_in;
   logic signed [VALUE_W-1:0] taken_ff, taken_in;
   status_type                status_ff, status_in;
   logic signed [VALUE_W-1:0] removed_ff, removed_in;
   logic [LEN_W-1:0]          length_ff, length_in;

   logic [AW-1:0]      pos_idx;
   logic [PW-1:0]      count_w, pos_w;
   logic               range_fail, full_fail;
   status_type         fail_code;
   logic [CW-1:0]      count_next;
   logic               ram_we;
   logic [AW-1:0]      ram_waddr, ram_raddr;
   logic [VALUE_W-1:0] ram_wdata, ram_rdata;

   assign pos_idx = AW'(pos_ff - POS_W'(1));
   assign count_w = PW'(count_ff);
   assign pos_w   = PW'(pos_ff);

   always_comb begin
      range_fail = (pos_ff == '0) ||
                   ((kind_ff == REQ_INSERT) ? (pos_w > count_w + PW'(1)) : (pos_w > count_w));
      full_fail  = (kind_ff == REQ_INSERT) && (count_ff == CW'(CAPACITY));
      if (range_fail) begin
         fail_code = ST_RANGE;
      end else if (full_fail) begin
         fail_code = ST_FULL;
      end else begin
         fail_code = ST_DONE;
      end
   end

   assign stat.is_delete = (kind_ff == REQ_DELETE);
   assign stat.fail      = range_fail || full_fail;
   // Insert shifts down to the request slot; delete shifts up to the last element.
   assign stat.more      = (kind_ff == REQ_INSERT) ? (idx_ff != pos_idx)
                                                   : (PW'(idx_ff) + PW'(1) != count_w);

   always_comb begin
      if (cmd.taken_rd) begin
         ram_raddr = pos_idx;
      end else if (kind_ff == REQ_INSERT) begin
         ram_raddr = idx_ff - AW'(1);
      end else begin
         ram_raddr = idx_ff + AW'(1);
      end
      ram_we    = cmd.shift_wr || cmd.value_wr;
      ram_waddr = cmd.value_wr ? pos_idx : idx_ff;
      ram_wdata = cmd.value_wr ? val_ff : ram_rdata;
   end

   ple_ram #(
      .WIDTH(VALUE_W),
      .DEPTH(CAPACITY)
   ) u_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   assign count_next = (kind_ff == REQ_INSERT) ? count_ff + CW'(1) : count_ff - CW'(1);

   always_comb begin
      kind_in    = kind_ff;
      pos_in     = pos_ff;
      val_in     = val_ff;
      idx_in     = idx_ff;
      count_in   = count_ff;
      taken_in   = taken_ff;
      status_in  = status_ff;
      removed_in = removed_ff;
      length_in  = length_ff;
      if (cmd.load) begin
         kind_in = req_type;
         pos_in  = req_position;
         val_in  = req_value;
         idx_in  = (req_type == REQ_INSERT) ? AW'(count_ff) : AW'(req_position - POS_W'(1));
      end
      if (cmd.shift_wr) begin
         idx_in = (kind_ff == REQ_INSERT) ? idx_ff - AW'(1) : idx_ff + AW'(1);
      end
      if (cmd.taken_cap) begin
         taken_in = ram_rdata;
      end
      if (cmd.commit) begin
         if (stat.fail) begin
            status_in  = fail_code;
            removed_in = '0;
            length_in  = LEN_W'(count_ff);
         end else begin
            count_in   = count_next;
            status_in  = ST_DONE;
            removed_in = (kind_ff == REQ_INSERT) ? '0 : taken_ff;
            length_in  = LEN_W'(count_next);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      kind_ff    <= kind_in;
      pos_ff     <= pos_in;
      val_ff     <= val_in;
      idx_ff     <= idx_in;
      taken_ff   <= taken_in;
      status_ff  <= status_in;
      removed_ff <= removed_in;
      length_ff  <= length_in;
   end

   assign rsp_status        = status_ff;
   assign rsp_removed_value = removed_ff;
   assign rsp_length        = length_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("element count above capacity");

   a_fail_keeps: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && stat.fail) |=> $stable(count_ff))
      else $error("failed request changed the element count");

   a_ins_grow: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && !stat.fail && !stat.is_delete) |=> count_ff == $past(count_ff) + CW'(1))
      else $error("insert did not grow the list by one");

   a_del_shrink: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && !stat.fail && stat.is_delete) |=> count_ff == $past(count_ff) - CW'(1))
      else $error("delete did not shrink the list by one");
endmodule

/* sv/positional_list_engine_unit.sv */
// Positional list engine: one request in flight. After the check state, the element RAM
// moves one element at a time, each move a read state and then a write state, from the
// end of the list down to the request position for an insert and from the request position
// up to the end for a delete. A failed request answers straight from the check state.
// The request side reopens in the cycle after the response transfer.
// Synchronous reset empties the list; element RAM is not cleared.
module positional_list_engine_unit #(
   parameter int unsigned CAPACITY = ple_pkg::CAPACITY_DEFAULT
) (
   input logic         clock,
   input logic         reset,
   ple_req_if.sink     req_bus,
   ple_rsp_if.source   rsp_bus
);
   import ple_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   ple_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_bus.valid),
      .req_ready(req_bus.ready),
      .rsp_valid(rsp_bus.valid),
      .rsp_ready(rsp_bus.ready),
      .stat     (stat),
      .cmd      (cmd)
   );

   ple_dpath #(
      .CAPACITY(CAPACITY)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .req_type         (req_bus.req_type),
      .req_position     (req_bus.position),
      .req_value        (req_bus.value),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_status       (rsp_bus.status),
      .rsp_removed_value(rsp_bus.removed_value),
      .rsp_length       (rsp_bus.length)
   );
endmodule

/* sim/testbench.sv */
// Self-checking testbench of positional_list_engine_unit: directed and random list requests.
// Depends on ple_pkg and on the channel interfaces in ple_if.sv.
`timescale 1ns / 100ps

module testbench;
   import ple_pkg::*;

   localparam int unsigned LIST_CAPACITY = 16;
   localparam int unsigned SETTLE_CYCLES = 2 * LIST_CAPACITY + 8;
   localparam int unsigned REPORT_LIMIT  = 100;

   typedef struct {
      status_type                status;
      logic signed [VALUE_W-1:0] removed_value;
      logic [LEN_W-1:0]          length;
   } list_result_type;

   logic clock = 1'b0;
   logic reset;

   ple_req_if req_bus ();
   ple_rsp_if rsp_bus ();

   positional_list_engine_unit #(
      .CAPACITY(LIST_CAPACITY)
   ) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus.sink),
      .rsp_bus(rsp_bus.source)
   );

   // Predicted contents of the list, front first, and the results still owed.
   logic signed [VALUE_W-1:0] list_image[$];
   list_result_type           pending_results[$];

   int unsigned error_count   = 0;
   int unsigned send_idle_pct = 0;
   int unsigned rsp_stall_pct = 0;

   always #5 clock = ~clock;

   task automatic report_mismatch(input string msg);
      if (error_count < REPORT_LIMIT) begin
         $display("[%0t] mismatch: %s", $realtime, msg);
      end
      error_count++;
   endtask

   // Applies one accepted request to the predicted list and queues its result.
   task automatic predict_list_request(input logic kind, input logic [POS_W-1:0] pos,
                                       input logic signed [VALUE_W-1:0] val);
      list_result_type res;
      int unsigned     count;
      count             = list_image.size();
      res.status        = ST_DONE;
      res.removed_value = '0;
      if (kind == REQ_INSERT) begin
         if (pos < 1 || pos > count + 1) begin
            res.status = ST_RANGE;
         end else if (count >= LIST_CAPACITY) begin
            res.status = ST_FULL;
         end else begin
            list_image.insert(pos - 1, val);
         end
      end else begin
         if (pos < 1 || pos > count) begin
            res.status = ST_RANGE;
         end else begin
            res.removed_value = list_image[pos - 1];
            list_image.delete(pos - 1);
         end
      end
      res.length = LEN_W'(list_image.size());
      pending_results.push_back(res);
   endtask

   // Sends one request. Valid stays high after the transfer, so a back-to-back
   // request never lowers and raises it within one time step.
   task automatic send_request(input logic kind, input logic [POS_W-1:0] pos,
                               input logic signed [VALUE_W-1:0] val);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.req_type <= kind;
      req_bus.position <= pos;
      req_bus.value    <= val;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) begin
         @(posedge clock);
      end
      predict_list_request(kind, pos, val);
   endtask

   task automatic wait_for_drain();
      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0) begin
         @(posedge clock);
      end
   endtask

   function automatic logic signed [VALUE_W-1:0] pick_value();
      case ($urandom_range(19))
         0:       return {1'b1, {(VALUE_W-1){1'b0}}};
         1:       return {1'b0, {(VALUE_W-1){1'b1}}};
         2:       return '0;
         3:       return '1;
         default: return $urandom;
      endcase
   endfunction

   // Response checker and receiver stall generator.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            if (pending_results.size() == 0) begin
               report_mismatch("response transfer with no request outstanding");
            end else begin
               list_result_type want;
               want = pending_results.pop_front();
               if (rsp_bus.status !== want.status) begin
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_bus.status, want.status));
               end
               if (rsp_bus.removed_value !== want.removed_value) begin
                  report_mismatch($sformatf("removed_value %0d, expected %0d",
                                            rsp_bus.removed_value, want.removed_value));
               end
               if (rsp_bus.length !== want.length) begin
                  report_mismatch($sformatf("length %0d, expected %0d",
                                            rsp_bus.length, want.length));
               end
            end
         end
         rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Empty-list errors, inserts at the front, middle and end, and deletes of each kind.
   task automatic test_directed_edges();
      send_request(REQ_DELETE, 8'd1, 32'sd5);
      send_request(REQ_DELETE, 8'd0, 32'sd0);
      send_request(REQ_INSERT, 8'd0, 32'sd7);
      send_request(REQ_INSERT, 8'd2, 32'sd7);
      send_request(REQ_INSERT, 8'd255, -32'sd1);
      send_request(REQ_INSERT, 8'd1, {1'b1, {(VALUE_W-1){1'b0}}});
      send_request(REQ_INSERT, 8'd2, {1'b0, {(VALUE_W-1){1'b1}}});
      send_request(REQ_INSERT, 8'd2, -32'sd1);
      send_request(REQ_INSERT, 8'd1, 32'sd0);
      send_request(REQ_DELETE, 8'd4, 32'sd0);
      send_request(REQ_DELETE, 8'd4, 32'sd0);
      send_request(REQ_DELETE, 8'd255, '1);
      send_request(REQ_DELETE, 8'd2, 32'sd0);
      send_request(REQ_DELETE, 8'd1, 32'sd0);
   endtask

   // Fills the list, then checks that a range error takes priority over full.
   task automatic test_full_list();
      while (list_image.size() < LIST_CAPACITY) begin
         send_request(REQ_INSERT, POS_W'($urandom_range(1, list_image.size() + 1)),
                      pick_value());
      end
      send_request(REQ_INSERT, 8'd1, 32'sd11);
      send_request(REQ_INSERT, POS_W'(LIST_CAPACITY + 1), 32'sd12);
      send_request(REQ_INSERT, POS_W'(LIST_CAPACITY + 2), 32'sd13);
      send_request(REQ_INSERT, 8'd0, 32'sd14);
      send_request(REQ_INSERT, 8'd255, 32'sd15);
      send_request(REQ_DELETE, POS_W'(LIST_CAPACITY), 32'sd0);
      send_request(REQ_DELETE, POS_W'(LIST_CAPACITY), 32'sd0);
      send_request(REQ_DELETE, 8'd1, 32'sd0);
   endtask

   // Mostly in-range requests whose mix drifts toward a random target length,
   // with some out-of-range positions mixed in.
   task automatic test_random_requests(input int unsigned num_items);
      int unsigned target_len;
      int unsigned count;
      logic        kind;
      logic [POS_W-1:0] pos;
      target_len = $urandom_range(LIST_CAPACITY);
      for (int unsigned i = 0; i < num_items; i++) begin
         if ($urandom_range(19) == 0) begin
            target_len = $urandom_range(LIST_CAPACITY);
         end
         count = list_image.size();
         if (count < target_len) begin
            kind = ($urandom_range(99) < 80) ? REQ_INSERT : REQ_DELETE;
         end else if (count > target_len) begin
            kind = ($urandom_range(99) < 20) ? REQ_INSERT : REQ_DELETE;
         end else begin
            kind = 1'($urandom_range(1));
         end
         if ($urandom_range(99) < 12 || (kind == REQ_DELETE && count == 0)) begin
            case ($urandom_range(3))
               0:       pos = '0;
               1:       pos = (kind == REQ_INSERT) ? POS_W'(count + 2) : POS_W'(count + 1);
               2:       pos = '1;
               default: pos = POS_W'($urandom_range(255));
            endcase
         end else if (kind == REQ_INSERT) begin
            pos = POS_W'($urandom_range(1, count + 1));
         end else begin
            pos = POS_W'($urandom_range(1, count));
         end
         send_request(kind, pos, pick_value());
      end
   endtask

   // The sender holds off until every owed response has been delivered.
   task automatic test_drain_pause();
      wait_for_drain();
      send_request(REQ_INSERT, POS_W'(list_image.size() + 1), pick_value());
      send_request(REQ_DELETE, 8'd1, 32'sd0);
   endtask

   initial begin
      reset            <= 1'b1;
      req_bus.valid    <= 1'b0;
      req_bus.req_type <= REQ_INSERT;
      req_bus.position <= '0;
      req_bus.value    <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_edges();
      test_full_list();

      send_idle_pct = 0;
      rsp_stall_pct = 0;
      test_random_requests(175);
      test_drain_pause();

      send_idle_pct = 53;
      rsp_stall_pct = 0;
      test_random_requests(175);

      send_idle_pct = 0;
      rsp_stall_pct = 53;
      test_random_requests(175);
      test_drain_pause();

      send_idle_pct = 7;
      rsp_stall_pct = 7;
      test_random_requests(175);

      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

/* positional_list_engine_unit.f */
sv/ple_pkg.sv
sv/ple_if.sv
sv/ple_ram.sv
sv/ple_ctrl.sv
sv/ple_dpath.sv
sv/positional_list_engine_unit.sv
sim/testbench.sv
